>>> sv/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg
// shared constants, record kinds and the record struct of the run-length
// encoder
// ----------------------------------------------------------------------------
`default_nettype none

package rle_pkg;

    localparam int LIT_DEPTH    = 32;
    localparam int ADDR_W       = $clog2(LIT_DEPTH);
    localparam int FILL_W       = $clog2(LIT_DEPTH + 1);
    localparam int REPEAT_LIMIT = 3;
    localparam int RUN_START    = REPEAT_LIMIT + 1;
    localparam int RUN_W        = 15;
    localparam logic [RUN_W-1:0] RUN_MAX = 15'h7FFF;

    typedef enum logic [1:0] {
        KIND_LIT_HDR  = 2'd0,
        KIND_LIT_BYTE = 2'd1,
        KIND_RUN      = 2'd2,
        KIND_END      = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [7:0]  rbyte;
        logic        last;
    } t_rec;

endpackage

`default_nettype wire

>>> sv/rle_buf_ram.sv
// ----------------------------------------------------------------------------
// rle_buf_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rle_buf_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/rle_out_reg.sv
// ----------------------------------------------------------------------------
// rle_out_reg
// output register of the encoder, holds one record word for the master side
// ----------------------------------------------------------------------------
`default_nettype none

module rle_out_reg import rle_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_rec        i_rec,
    output logic             o_can_load,
    input  wire logic        i_m_axis_tready,
    output logic             o_m_axis_tvalid,
    output logic [39:0]      o_m_axis_tdata,   // record_value, record_byte
    output logic [1:0]       o_m_axis_tuser,   // record_kind
    output logic             o_m_axis_tlast    // last_for_item
);

    logic r_valid;
    t_rec r_rec;

    assign o_can_load = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_rec <= i_rec;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {r_rec.rbyte, r_rec.value};
    assign o_m_axis_tuser  = r_rec.kind;
    assign o_m_axis_tlast  = r_rec.last;

endmodule

`default_nettype wire

>>> sv/rle_literal_run_encoder.sv
// ----------------------------------------------------------------------------
// rle_literal_run_encoder
// run-length encoder turning a byte stream into literal, run and end records
//
//  channel  | dir | tdata                          | tuser       | tlast
//  s_axis   | in  | [7:0] data_byte                | -           | end_of_stream
//  m_axis   | out | [31:0] record_value, [39:32]   | record_kind | last_for_item
//           |     | record_byte                    |             |
//
//  an input word that causes no record keeps the encoder idle and ready
//  a word causing records holds off input until all load, one record per
//  cycle unless stalled; the ram read port streams literal bytes one per cycle
//  reset is synchronous; the buffer ram needs no clearing pass
//  a stalled master side holds the sequencer and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module rle_literal_run_encoder import rle_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // data_byte
    input  wire logic        i_s_axis_tlast,   // end_of_stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // record_value, record_byte
    output logic [1:0]       o_m_axis_tuser,   // record_kind
    output logic             o_m_axis_tlast    // last_for_item
);

    typedef enum logic [1:0] {
        MODE_INIT = 2'd0,
        MODE_LIT  = 2'd1,
        MODE_RUN  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE_RUN,
        ST_LIT_HDR,
        ST_LIT_BYTE,
        ST_POST_RUN,
        ST_END
    } t_state;

    function automatic t_state pick(input logic lit, input logic post, input logic fin);
        t_state s;
        if (lit) begin
            s = ST_LIT_HDR;
        end else if (post) begin
            s = ST_POST_RUN;
        end else if (fin) begin
            s = ST_END;
        end else begin
            s = ST_IDLE;
        end
        return s;
    endfunction

    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [7:0]         r_prev, n_prev;
    logic               r_prev_valid, n_prev_valid;
    logic [1:0]         r_repeat, n_repeat;
    logic [7:0]         r_run_byte, n_run_byte;
    logic [RUN_W-1:0]   r_run_len, n_run_len;
    logic [31:0]        r_total, n_total;

    logic [RUN_W-1:0]   r_pre_len, n_pre_len;
    logic [7:0]         r_pre_byte, n_pre_byte;
    logic [FILL_W-1:0]  r_lit_cnt, n_lit_cnt;
    logic [RUN_W-1:0]   r_post_len, n_post_len;
    logic [7:0]         r_post_byte, n_post_byte;
    logic [31:0]        r_end_total, n_end_total;
    logic               r_pend_lit, n_pend_lit;
    logic               r_pend_post, n_pend_post;
    logic               r_pend_end, n_pend_end;
    logic [ADDR_W-1:0]  r_idx, n_idx;

    logic               acc;
    logic               can_load;
    logic               load;
    t_rec               rec;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [7:0]         ram_q;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign acc = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        logic [FILL_W:0]   fill1;
        logic [2:0]        rep1;
        logic              eq;
        logic              pre;
        logic [FILL_W-1:0] idx_nx;
        t_state            nxt;

        n_state      = r_state;
        n_mode       = r_mode;
        n_fill       = r_fill;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_repeat     = r_repeat;
        n_run_byte   = r_run_byte;
        n_run_len    = r_run_len;
        n_total      = r_total;
        n_pre_len    = r_pre_len;
        n_pre_byte   = r_pre_byte;
        n_lit_cnt    = r_lit_cnt;
        n_post_len   = r_post_len;
        n_post_byte  = r_post_byte;
        n_end_total  = r_end_total;
        n_pend_lit   = r_pend_lit;
        n_pend_post  = r_pend_post;
        n_pend_end   = r_pend_end;
        n_idx        = r_idx;
        ram_we       = 1'b0;
        ram_waddr    = r_fill[ADDR_W-1:0];
        ram_re       = 1'b0;
        ram_raddr    = '0;
        load         = 1'b0;
        rec          = '0;
        fill1        = {1'b0, r_fill} + 1'b1;
        rep1         = 3'd1;
        eq           = r_prev_valid && (r_prev == i_s_axis_tdata);
        pre          = 1'b0;
        idx_nx       = FILL_W'(r_idx) + 1'b1;
        nxt          = ST_IDLE;

        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_pend_lit  = 1'b0;
                    n_pend_post = 1'b0;
                    n_pend_end  = 1'b0;
                    n_total     = r_total + 32'd1;
                    case (r_mode)
                        MODE_LIT: begin
                            ram_we = (r_fill < FILL_W'(LIT_DEPTH));
                            rep1 = eq ? ({1'b0, r_repeat} + 3'd1) : 3'd1;
                            n_prev = i_s_axis_tdata;
                            n_prev_valid = 1'b1;
                            if (eq && (rep1 > 3'(REPEAT_LIMIT))) begin
                                if (fill1 > (FILL_W+1)'(RUN_START)) begin
                                    n_lit_cnt  = FILL_W'(fill1 - (FILL_W+1)'(RUN_START));
                                    n_pend_lit = 1'b1;
                                end
                                n_mode     = MODE_RUN;
                                n_run_byte = i_s_axis_tdata;
                                n_run_len  = RUN_W'(RUN_START);
                                n_fill     = '0;
                                n_repeat   = '0;
                            end else begin
                                n_repeat = rep1[1:0];
                                n_fill   = fill1[FILL_W-1:0];
                                if (fill1 >= (FILL_W+1)'(LIT_DEPTH)) begin
                                    n_lit_cnt    = fill1[FILL_W-1:0];
                                    n_pend_lit   = 1'b1;
                                    n_fill       = '0;
                                    n_prev_valid = 1'b0;
                                    n_repeat     = '0;
                                end
                            end
                        end
                        MODE_RUN: begin
                            if (i_s_axis_tdata == r_run_byte) begin
                                if (r_run_len >= RUN_MAX) begin
                                    pre        = 1'b1;
                                    n_pre_len  = RUN_MAX;
                                    n_pre_byte = r_run_byte;
                                    n_run_len  = RUN_W'(1);
                                end else begin
                                    n_run_len = r_run_len + 1'b1;
                                end
                            end else begin
                                pre          = 1'b1;
                                n_pre_len    = r_run_len;
                                n_pre_byte   = r_run_byte;
                                ram_we       = 1'b1;
                                ram_waddr    = '0;
                                n_mode       = MODE_LIT;
                                n_fill       = FILL_W'(1);
                                n_prev       = i_s_axis_tdata;
                                n_prev_valid = 1'b1;
                                n_repeat     = 2'd1;
                            end
                        end
                        default: begin
                            ram_we       = 1'b1;
                            ram_waddr    = '0;
                            n_mode       = MODE_LIT;
                            n_fill       = FILL_W'(1);
                            n_prev       = i_s_axis_tdata;
                            n_prev_valid = 1'b1;
                            n_repeat     = 2'd1;
                        end
                    endcase
                    if (i_s_axis_tlast) begin
                        if (n_mode == MODE_LIT && n_fill != '0) begin
                            n_lit_cnt  = n_fill;
                            n_pend_lit = 1'b1;
                        end else if (n_mode == MODE_RUN) begin
                            n_pend_post = 1'b1;
                            n_post_len  = n_run_len;
                            n_post_byte = n_run_byte;
                        end
                        n_pend_end   = 1'b1;
                        n_end_total  = n_total;
                        n_mode       = MODE_INIT;
                        n_fill       = '0;
                        n_prev       = '0;
                        n_prev_valid = 1'b0;
                        n_repeat     = '0;
                        n_run_byte   = '0;
                        n_run_len    = '0;
                        n_total      = '0;
                    end
                    n_state = pre ? ST_PRE_RUN : pick(n_pend_lit, n_pend_post, n_pend_end);
                end
            end
            ST_PRE_RUN: begin
                if (can_load) begin
                    nxt        = pick(r_pend_lit, r_pend_post, r_pend_end);
                    load       = 1'b1;
                    rec.kind   = KIND_RUN;
                    rec.value  = 32'(r_pre_len);
                    rec.rbyte  = r_pre_byte;
                    rec.last   = (nxt == ST_IDLE);
                    n_state    = nxt;
                end
            end
            ST_LIT_HDR: begin
                if (can_load) begin
                    load      = 1'b1;
                    rec.kind  = KIND_LIT_HDR;
                    rec.value = 32'(r_lit_cnt);
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                    n_idx     = '0;
                    n_state   = ST_LIT_BYTE;
                end
            end
            ST_LIT_BYTE: begin
                if (can_load) begin
                    load      = 1'b1;
                    rec.kind  = KIND_LIT_BYTE;
                    rec.rbyte = ram_q;
                    if (idx_nx < r_lit_cnt) begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_nx[ADDR_W-1:0];
                        n_idx     = idx_nx[ADDR_W-1:0];
                    end else begin
                        nxt        = pick(1'b0, r_pend_post, r_pend_end);
                        rec.last   = (nxt == ST_IDLE);
                        n_pend_lit = 1'b0;
                        n_state    = nxt;
                    end
                end
            end
            ST_POST_RUN: begin
                if (can_load) begin
                    nxt         = pick(1'b0, 1'b0, r_pend_end);
                    load        = 1'b1;
                    rec.kind    = KIND_RUN;
                    rec.value   = 32'(r_post_len);
                    rec.rbyte   = r_post_byte;
                    rec.last    = (nxt == ST_IDLE);
                    n_pend_post = 1'b0;
                    n_state     = nxt;
                end
            end
            ST_END: begin
                if (can_load) begin
                    load       = 1'b1;
                    rec.kind   = KIND_END;
                    rec.value  = r_end_total;
                    rec.last   = 1'b1;
                    n_pend_end = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= MODE_INIT;
            r_fill       <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_repeat     <= '0;
            r_run_byte   <= '0;
            r_run_len    <= '0;
            r_total      <= '0;
            r_pend_lit   <= 1'b0;
            r_pend_post  <= 1'b0;
            r_pend_end   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_fill       <= n_fill;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_repeat     <= n_repeat;
            r_run_byte   <= n_run_byte;
            r_run_len    <= n_run_len;
            r_total      <= n_total;
            r_pend_lit   <= n_pend_lit;
            r_pend_post  <= n_pend_post;
            r_pend_end   <= n_pend_end;
        end
        r_pre_len   <= n_pre_len;
        r_pre_byte  <= n_pre_byte;
        r_lit_cnt   <= n_lit_cnt;
        r_post_len  <= n_post_len;
        r_post_byte <= n_post_byte;
        r_end_total <= n_end_total;
        r_idx       <= n_idx;
    end

    rle_buf_ram #(
        .DEPTH (LIT_DEPTH),
        .WIDTH (8)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    rle_out_reg u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_rec           (rec),
        .o_can_load      (can_load),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    a_run_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_RUN) |-> (r_run_len != '0))
        else $error("run mode with zero run length");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(LIT_DEPTH))
        else $error("literal fill level reached buffer depth");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIT_BYTE) |-> (FILL_W'(r_idx) < r_lit_cnt))
        else $error("literal read beyond flush count");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> can_load)
        else $error("output register overwritten");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_s_axis_tlast) |=> (r_mode == MODE_INIT && r_total == '0 && r_pend_end))
        else $error("end of stream did not clear state");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the run-length encoder against an in-bench model of its records.
// byte words go in over the slave stream and the record words coming out are
// compared field by field with the records the model predicts, in order.
// directed streams come first, then random streams under random stalls,
// a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------

module testbench;
    import rle_pkg::*;

    typedef enum logic [1:0] {
        ENC_IDLE = 2'd0,
        ENC_LIT  = 2'd1,
        ENC_RUN  = 2'd2
    } t_enc_mode;

    class record_scoreboard;
        t_rec        pending_records[$];
        int          errors;
        t_enc_mode   mode;
        logic [7:0]  lit_buf[LIT_DEPTH];
        int          fill;
        logic [7:0]  prev_byte;
        bit          prev_ok;
        int          rep;
        logic [7:0]  run_byte;
        int          run_len;
        logic [31:0] total;

        function new();
            errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            mode      = ENC_IDLE;
            fill      = 0;
            prev_byte = 8'h00;
            prev_ok   = 1'b0;
            rep       = 0;
            run_byte  = 8'h00;
            run_len   = 0;
            total     = 32'd0;
        endfunction

        function void add_record(t_kind kind, logic [31:0] value, logic [7:0] rbyte);
            t_rec r;
            r.kind  = kind;
            r.value = value;
            r.rbyte = rbyte;
            r.last  = 1'b0;
            pending_records.push_back(r);
        endfunction

        function void flush_literals();
            if (fill == 0) return;
            add_record(KIND_LIT_HDR, 32'(fill), 8'h00);
            for (int i = 0; i < fill && i < LIT_DEPTH; i++)
                add_record(KIND_LIT_BYTE, 32'd0, lit_buf[i]);
        endfunction

        function void start_literal(logic [7:0] b);
            mode       = ENC_LIT;
            lit_buf[0] = b;
            fill       = 1;
            prev_byte  = b;
            prev_ok    = 1'b1;
            rep        = 1;
        endfunction

        // predicts the records caused by one accepted byte word
        function void encode_byte(logic [7:0] b, logic eos);
            int first;
            first = pending_records.size();
            total = total + 32'd1;
            case (mode)
                ENC_LIT: begin
                    if (fill < LIT_DEPTH) lit_buf[fill] = b;
                    fill++;
                    if (prev_ok && prev_byte == b) begin
                        rep++;
                        if (rep > REPEAT_LIMIT) begin
                            if (fill > rep) begin
                                fill -= rep;
                                flush_literals();
                            end
                            mode     = ENC_RUN;
                            run_byte = b;
                            run_len  = rep;
                            fill     = 0;
                            rep      = 0;
                        end
                    end else begin
                        rep = 1;
                    end
                    prev_byte = b;
                    prev_ok   = 1'b1;
                    if (mode == ENC_LIT && fill >= LIT_DEPTH) begin
                        flush_literals();
                        fill    = 0;
                        prev_ok = 1'b0;
                        rep     = 0;
                    end
                end
                ENC_RUN: begin
                    if (b == run_byte) begin
                        if (run_len >= int'(RUN_MAX)) begin
                            add_record(KIND_RUN, 32'(RUN_MAX), run_byte);
                            run_len = 1;
                        end else begin
                            run_len++;
                        end
                    end else begin
                        add_record(KIND_RUN, 32'(run_len), run_byte);
                        start_literal(b);
                    end
                end
                default: begin
                    start_literal(b);
                end
            endcase
            if (eos) begin
                if (mode == ENC_LIT)
                    flush_literals();
                else if (mode == ENC_RUN)
                    add_record(KIND_RUN, 32'(run_len), run_byte);
                add_record(KIND_END, total, 8'h00);
                clear_stream();
            end
            if (pending_records.size() > first)
                pending_records[pending_records.size() - 1].last = 1'b1;
        endfunction

        function void check_record(t_kind kind, logic [31:0] value, logic [7:0] rbyte,
                                   logic last);
            t_rec want;
            if (pending_records.size() == 0) begin
                $error("unexpected record word: kind %0d value %0d byte %0d",
                       kind, value, rbyte);
                errors++;
                return;
            end
            want = pending_records.pop_front();
            if (want.kind !== kind) begin
                $error("record_kind: expected %0d, actual %0d", want.kind, kind);
                errors++;
            end
            if (want.value !== value) begin
                $error("record_value: expected %0d, actual %0d", want.value, value);
                errors++;
            end
            if (want.rbyte !== rbyte) begin
                $error("record_byte: expected %0d, actual %0d", want.rbyte, rbyte);
                errors++;
            end
            if (want.last !== last) begin
                $error("last_for_item: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // data_byte
    logic        i_s_axis_tlast;   // end_of_stream
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;   // record_value, record_byte
    logic [1:0]  o_m_axis_tuser;   // record_kind
    logic        o_m_axis_tlast;   // last_for_item

    record_scoreboard sb;
    int sent;
    int sink_hold_len;
    bit quiet;

    rle_literal_run_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.encode_byte(b, eos);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_run(input logic [7:0] b, input int len, input logic eos);
        for (int i = 0; i < len; i++)
            send_byte(b, eos && (i == len - 1));
    endtask

    task automatic drain_records();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_records.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // receiver: random stalls, ready stretches and one long hold-off on request
    initial begin : sink
        int n;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_len > 0) begin
                n = sink_hold_len;
                sink_hold_len = 0;
                i_m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!quiet) repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end
        end
    end

    initial begin : monitor
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_record(t_kind'(o_m_axis_tuser), o_m_axis_tdata[31:0],
                                o_m_axis_tdata[39:32], o_m_axis_tlast);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int start;
        int pick;
        int len;
        logic [7:0] alpha[4];
        logic [7:0] base;
        logic [7:0] step;
        bit pressed;
        bit paused;

        sb            = new();
        sent          = 0;
        sink_hold_len = 0;
        quiet         = 1'b0;
        pressed       = 1'b0;
        paused        = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tlast  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single byte stream ended from the initial state
        send_byte(8'h00, 1'b1);
        // run closed by a different byte, then end in literal mode
        send_run(8'hFF, 4, 1'b0);
        send_byte(8'h12, 1'b1);
        // literal before a run, stream ending inside the run
        send_byte(8'h01, 1'b0);
        send_run(8'h02, 5, 1'b1);
        // alternating bytes, three repeats that stay literal
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_run(8'h07, 3, 1'b0);
        send_byte(8'h08, 1'b1);
        // buffer full with a run crossing the flush
        for (int i = 0; i < 30; i++) send_byte(8'(i * 7 + 1), 1'b0);
        send_run(8'h77, 5, 1'b1);

        start = sent;
        while (sent < start + 126) begin
            if (!pressed && sent > start + 40) begin
                sink_hold_len = 400;
                pressed = 1'b1;
            end
            if (!paused && sent > start + 75) begin
                drain_records();
                paused = 1'b1;
            end
            if (sent > start + 100) quiet = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                foreach (alpha[k]) alpha[k] = 8'($urandom_range(0, 255));
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_byte(alpha[$urandom_range(0, 3)], 1'b0);
            end else if (pick <= 6) begin
                send_run(8'($urandom_range(0, 255)), $urandom_range(1, 12), 1'b0);
            end else if (pick == 7) begin
                base = 8'($urandom_range(0, 255));
                step = 8'($urandom_range(0, 127) * 2 + 1);
                len  = $urandom_range(28, 40);
                for (int i = 0; i < len; i++) send_byte(base + 8'(i) * step, 1'b0);
            end else if (pick == 8) begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end

        drain_records();
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
